[hdl/safdo_pkg.sv]
// Package for the stereo audio ring FIFO: sizes, payload types, mode and
// register codes, pointer helper. No dependencies.
`default_nettype none

package safdo_pkg;

  localparam int RING_FRAMES = 16384;
  localparam int MAX_BURST   = 64;

  localparam int PTR_W    = $clog2(RING_FRAMES);
  localparam int CNT_W    = $clog2(RING_FRAMES + 1);
  localparam int SAMPLE_W = 16;
  localparam int FRAME_W  = 2 * SAMPLE_W;
  localparam int BURST_W  = 7;
  localparam int FILL_W   = 15;
  localparam int DROP_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic [1:0]                  mode_t;
  typedef logic signed [SAMPLE_W-1:0]  sample_t;
  typedef logic [BURST_W-1:0]          burst_t;
  typedef logic [FILL_W-1:0]           fill_t;
  typedef logic [DROP_W-1:0]           drop_t;
  typedef logic [PTR_W-1:0]            ptr_t;
  typedef logic [CNT_W-1:0]            cnt_t;
  typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]       cfg_data_t;

  localparam mode_t MODE_PUSH  = 2'd0;
  localparam mode_t MODE_POP   = 2'd1;
  localparam mode_t MODE_CLEAR = 2'd2;

  localparam cfg_idx_t CFG_RING_READY   = 2'd0;
  localparam cfg_idx_t CFG_SINK_ENABLED = 2'd1;

  // ring pointer increment with wrap
  function automatic ptr_t next_ptr(input ptr_t p);
    return (p == PTR_W'(RING_FRAMES - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

[hdl/safdo_if.sv]
// Handshake channel interfaces for the stereo audio ring FIFO.
// Depends on safdo_pkg.
`default_nettype none

interface safdo_in_if;
  import safdo_pkg::*;
  logic    valid;
  logic    ready;
  mode_t   mode;
  sample_t left_sample;
  sample_t right_sample;
  burst_t  burst_frames;
  modport source (output valid, mode, left_sample, right_sample, burst_frames,
                  input ready);
  modport sink (input valid, mode, left_sample, right_sample, burst_frames,
                output ready);
endinterface

interface safdo_out_if;
  import safdo_pkg::*;
  logic    valid;
  logic    ready;
  logic    frame_valid;
  sample_t left_out;
  sample_t right_out;
  logic    last_frame;
  fill_t   fill_frames;
  drop_t   dropped_frames;
  modport source (output valid, frame_valid, left_out, right_out, last_frame,
                  fill_frames, dropped_frames, input ready);
  modport sink (input valid, frame_valid, left_out, right_out, last_frame,
                fill_frames, dropped_frames, output ready);
endinterface

interface safdo_cfg_if;
  import safdo_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/safdo_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module safdo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/stereo_audio_fifo_drop_oldest.sv]
// Stereo audio ring FIFO, drops the oldest frame on overrun. Push and clear complete in
// idle and can be accepted back to back. A pop of N frames reads the frame RAM on
// acceptance, captures the RAM's registered read data in S_RD and holds it in S_OUT
// until taken, then reads the next frame. Empty pop: result in the cycle after acceptance.
// Reset (rst_n, sync, active low) clears pointers, level, drop count and config;
// the frame RAM is not cleared, there is no sweep after reset.
// Depends on safdo_pkg, safdo_if, safdo_ram.
`default_nettype none

module stereo_audio_fifo_drop_oldest (
  input  wire logic        clk,
  input  wire logic        rst_n,
  safdo_in_if.sink         in_ch,
  safdo_out_if.source      out_ch,
  safdo_cfg_if.sink        cfg_ch
);
  import safdo_pkg::*;

  // sequencer: idle takes transactions, rd waits on RAM data, out holds a result
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t  state_r, state_nxt;
  ptr_t    rd_ptr_r, rd_ptr_nxt;
  ptr_t    wr_ptr_r, wr_ptr_nxt;
  cnt_t    count_r, count_nxt;
  drop_t   drop_r, drop_nxt;
  burst_t  rem_r, rem_nxt;        // frames of the current pop still to read
  logic    ring_ready_r;
  logic    sink_en_r;

  // output register
  logic    o_fvalid_r, o_fvalid_nxt;
  sample_t o_left_r, o_left_nxt;
  sample_t o_right_r, o_right_nxt;
  logic    o_last_r, o_last_nxt;
  fill_t   o_fill_r, o_fill_nxt;
  drop_t   o_drop_r, o_drop_nxt;

  // frame RAM port
  logic                ram_we;
  logic                ram_re;
  logic [FRAME_W-1:0]  ram_rdata;

  burst_t  burst_sat;
  burst_t  take;

  safdo_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (RING_FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata ({in_ch.right_sample, in_ch.left_sample}),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = (state_r == S_OUT);
  assign out_ch.frame_valid    = o_fvalid_r;
  assign out_ch.left_out       = o_left_r;
  assign out_ch.right_out      = o_right_r;
  assign out_ch.last_frame     = o_last_r;
  assign out_ch.fill_frames    = o_fill_r;
  assign out_ch.dropped_frames = o_drop_r;

  // burst clamp, then limit to what is queued
  always_comb begin
    burst_sat = (32'(in_ch.burst_frames) > 32'(MAX_BURST)) ?
                BURST_W'(MAX_BURST) : in_ch.burst_frames;
    take = (32'(count_r) < 32'(burst_sat)) ? BURST_W'(count_r) : burst_sat;
  end

  always_comb begin
    state_nxt    = state_r;
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    count_nxt    = count_r;
    drop_nxt     = drop_r;
    rem_nxt      = rem_r;
    o_fvalid_nxt = o_fvalid_r;
    o_left_nxt   = o_left_r;
    o_right_nxt  = o_right_r;
    o_last_nxt   = o_last_r;
    o_fill_nxt   = o_fill_r;
    o_drop_nxt   = o_drop_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && ring_ready_r) begin
          case (in_ch.mode)
            MODE_PUSH: begin
              if (sink_en_r) begin
                ram_we     = 1'b1;
                wr_ptr_nxt = next_ptr(wr_ptr_r);
                if (count_r == CNT_W'(RING_FRAMES)) begin
                  // full: oldest frame goes, level unchanged
                  rd_ptr_nxt = next_ptr(rd_ptr_r);
                  if (drop_r != '1) begin
                    drop_nxt = drop_r + 1'b1;
                  end
                end else begin
                  count_nxt = count_r + 1'b1;
                end
              end
            end
            MODE_POP: begin
              if (take == '0) begin
                // empty pop: single invalid result marked last
                o_fvalid_nxt = 1'b0;
                o_left_nxt   = '0;
                o_right_nxt  = '0;
                o_last_nxt   = 1'b1;
                o_fill_nxt   = FILL_W'(count_r);
                o_drop_nxt   = drop_r;
                state_nxt    = S_OUT;
              end else begin
                ram_re     = 1'b1;
                rd_ptr_nxt = next_ptr(rd_ptr_r);
                count_nxt  = count_r - 1'b1;
                rem_nxt    = take - 1'b1;
                state_nxt  = S_RD;
              end
            end
            MODE_CLEAR: begin
              rd_ptr_nxt = '0;
              wr_ptr_nxt = '0;
              count_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        o_fvalid_nxt = 1'b1;
        o_left_nxt   = ram_rdata[SAMPLE_W-1:0];
        o_right_nxt  = ram_rdata[FRAME_W-1:SAMPLE_W];
        o_last_nxt   = (rem_r == '0);
        o_fill_nxt   = FILL_W'(count_r);
        o_drop_nxt   = drop_r;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) begin
          if (rem_r != '0) begin
            ram_re     = 1'b1;
            rd_ptr_nxt = next_ptr(rd_ptr_r);
            count_nxt  = count_r - 1'b1;
            rem_nxt    = rem_r - 1'b1;
            state_nxt  = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      count_r      <= '0;
      drop_r       <= '0;
      rem_r        <= '0;
      ring_ready_r <= 1'b0;
      sink_en_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
      drop_r   <= drop_nxt;
      rem_r    <= rem_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_RING_READY:   ring_ready_r <= cfg_ch.data[0];
          CFG_SINK_ENABLED: sink_en_r    <= cfg_ch.data[0];
          default: ;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    o_fvalid_r <= o_fvalid_nxt;
    o_left_r   <= o_left_nxt;
    o_right_r  <= o_right_nxt;
    o_last_r   <= o_last_nxt;
    o_fill_r   <= o_fill_nxt;
    o_drop_r   <= o_drop_nxt;
  end

`ifndef SYNTH
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(RING_FRAMES))
    else $error("ring level above capacity");

  a_rd_follows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |=> state_r == S_OUT)
    else $error("RAM data not captured");

  a_drop_monotonic: assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> drop_r >= $past(drop_r))
    else $error("drop count went down");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last_frame |=> state_r == S_IDLE)
    else $error("pop continued past last frame");

  a_push_keeps_pop: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_IDLE && !ram_re)
    else $error("write during pop sequence");
`endif

endmodule

`default_nettype wire

[tb/tb_stereo_audio_fifo_drop_oldest.sv]
// Testbench for stereo_audio_fifo_drop_oldest: a frame ring predictor class
// checks every popped frame; plain tasks drive the in and cfg channels, an always block the out ready.
// Depends on safdo_pkg, safdo_if and the block's RTL.

import safdo_pkg::*;

typedef struct {
  logic    frame_valid;
  sample_t left_out;
  sample_t right_out;
  logic    last_frame;
  fill_t   fill_frames;
  drop_t   dropped_frames;
} ring_result_t;

// Frame ring predictor: own copy of the ring, pointers, level, drop count and
// the two config bits; queues the frames each pop should return.
class frame_ring_predictor;
  bit [FRAME_W-1:0] frames [RING_FRAMES];
  int unsigned      rd_ptr;
  int unsigned      wr_ptr;
  int unsigned      level;
  drop_t            drop_total;
  bit               ring_ready;
  bit               sink_enabled;
  ring_result_t     expected_frames[$];
  int unsigned      errors;

  function new();
    rd_ptr       = 0;
    wr_ptr       = 0;
    level        = 0;
    drop_total   = '0;
    ring_ready   = 1'b0;
    sink_enabled = 1'b0;
    errors       = 0;
  endfunction

  function void write_reg(cfg_idx_t idx, cfg_data_t data);
    case (idx)
      CFG_RING_READY:   ring_ready   = data[0];
      CFG_SINK_ENABLED: sink_enabled = data[0];
      default: ;
    endcase
  endfunction

  function void add_result(logic fv, sample_t l, sample_t r, logic last);
    ring_result_t res;
    res.frame_valid    = fv;
    res.left_out       = l;
    res.right_out      = r;
    res.last_frame     = last;
    res.fill_frames    = fill_t'(level);
    res.dropped_frames = drop_total;
    expected_frames.push_back(res);
  endfunction

  // one accepted input transaction
  function void take_request(mode_t mode, sample_t l, sample_t r, burst_t burst);
    int unsigned cap;
    int unsigned take;
    bit [FRAME_W-1:0] word;
    if (!ring_ready) return;
    case (mode)
      MODE_PUSH: begin
        if (sink_enabled) begin
          // full ring: oldest frame goes first
          if (level >= RING_FRAMES) begin
            rd_ptr = (rd_ptr + 1) % RING_FRAMES;
            level--;
            if (drop_total != '1) drop_total++;
          end
          frames[wr_ptr] = {r, l};
          wr_ptr = (wr_ptr + 1) % RING_FRAMES;
          level++;
        end
      end
      MODE_CLEAR: begin
        rd_ptr = 0;
        wr_ptr = 0;
        level  = 0;
      end
      MODE_POP: begin
        cap  = (burst > MAX_BURST) ? MAX_BURST : burst;
        take = (cap < level) ? cap : level;
        if (take == 0) begin
          add_result(1'b0, '0, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < take; i++) begin
            word   = frames[rd_ptr];
            rd_ptr = (rd_ptr + 1) % RING_FRAMES;
            level--;
            add_result(1'b1, word[SAMPLE_W-1:0], word[FRAME_W-1:SAMPLE_W], i + 1 == take);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function void flag(string field, logic signed [32:0] want, logic signed [32:0] got);
    errors++;
    if (errors <= 40)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endfunction

  function void check_frame(ring_result_t got);
    ring_result_t want;
    if (expected_frames.size() == 0) begin
      errors++;
      if (errors <= 40)
        $display("%0t: unexpected frame, expected none, actual valid=%0b L=%0d R=%0d",
                 $time, got.frame_valid, got.left_out, got.right_out);
      return;
    end
    want = expected_frames.pop_front();
    if (got.frame_valid !== want.frame_valid)
      flag("frame_valid", want.frame_valid, got.frame_valid);
    if (got.left_out !== want.left_out) flag("left_out", want.left_out, got.left_out);
    if (got.right_out !== want.right_out) flag("right_out", want.right_out, got.right_out);
    if (got.last_frame !== want.last_frame)
      flag("last_frame", want.last_frame, got.last_frame);
    if (got.fill_frames !== want.fill_frames)
      flag("fill_frames", want.fill_frames, got.fill_frames);
    if (got.dropped_frames !== want.dropped_frames)
      flag("dropped_frames", want.dropped_frames, got.dropped_frames);
  endfunction
endclass

module tb_stereo_audio_fifo_drop_oldest;

  localparam mode_t MODE_UNUSED  = 2'd3;   // spare mode code, block must ignore it
  localparam int    IDLE_PCT     = 35;     // chance per cycle that a side idles
  localparam int    HOLD_CYCLES  = 300;    // long receiver hold-off for back-pressure
  localparam int    DRAIN_CYCLES = 16;     // lets trailing pushes/clears retire; pops end on last_frame
  localparam int    CYCLE_LIMIT  = 1000000;

  logic clk;
  logic rst_n;

  safdo_in_if  in_ch();
  safdo_out_if out_ch();
  safdo_cfg_if cfg_ch();

  stereo_audio_fifo_drop_oldest DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  frame_ring_predictor pred = new();

  bit          tx_calm;      // sender offers a transaction every cycle
  bit          rx_calm;      // receiver keeps ready high
  bit          hold_req;     // asks the receiver process for a long hold-off
  int unsigned hold_left;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: covers a lost frame or a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: ready changes on the falling edge. A hold-off request is counted
  // down here, independent of the sender, so the ring engine backs up into
  // the input channel.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (rx_calm) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result monitor: a transaction completes at a rising edge with valid and ready.
  always @(posedge clk) begin
    ring_result_t got;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.frame_valid    = out_ch.frame_valid;
      got.left_out       = out_ch.left_out;
      got.right_out      = out_ch.right_out;
      got.last_frame     = out_ch.last_frame;
      got.fill_frames    = out_ch.fill_frames;
      got.dropped_frames = out_ch.dropped_frames;
      pred.check_frame(got);
    end
  end

  // Offer one input transaction, with random idle cycles ahead of it. Valid is
  // left high after acceptance; the next call either lowers it (gap) or just
  // swaps the payload.
  task automatic send_item(mode_t m, sample_t l, sample_t r, burst_t b);
    while (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= m;
    in_ch.left_sample  <= l;
    in_ch.right_sample <= r;
    in_ch.burst_frames <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pred.take_request(m, l, r, b);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    pred.write_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drop valid, let every queued frame come out, then give trailing pushes
  // or clears time to retire. Config writes only follow this.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pred.expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(bit ready_bit, bit sink_bit);
    wait_idle();
    write_reg(CFG_RING_READY, cfg_data_t'(ready_bit));
    write_reg(CFG_SINK_ENABLED, cfg_data_t'(sink_bit));
  endtask

  // Mostly short bursts so the level builds up; zero and oversize bursts too.
  function automatic burst_t rand_burst();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5)  return burst_t'(0);
    if (pick < 12) return burst_t'($urandom_range(127, 65));
    if (pick < 20) return burst_t'($urandom_range(64, 5));
    return burst_t'($urandom_range(4, 1));
  endfunction

  task automatic push_frames(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_item(MODE_PUSH, sample_t'($urandom), sample_t'($urandom), rand_burst());
  endtask

  // Random transactions until 'want' of them did something, capped at max_raw.
  task automatic random_items(int unsigned want, int unsigned max_raw);
    int unsigned live_cnt;
    int unsigned raw_cnt;
    int unsigned pick;
    mode_t       m;
    live_cnt = 0;
    raw_cnt  = 0;
    while (live_cnt < want && raw_cnt < max_raw) begin
      pick = $urandom_range(99);
      if (pick < 58)      m = MODE_PUSH;
      else if (pick < 90) m = MODE_POP;
      else if (pick < 94) m = MODE_CLEAR;
      else                m = MODE_UNUSED;
      if (pred.ring_ready && (m == MODE_POP || m == MODE_CLEAR ||
                              (m == MODE_PUSH && pred.sink_enabled)))
        live_cnt++;
      raw_cnt++;
      send_item(m, sample_t'($urandom), sample_t'($urandom), rand_burst());
    end
  endtask

  initial begin
    // every block input known from time zero
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = MODE_PUSH;
    in_ch.left_sample   = '0;
    in_ch.right_sample  = '0;
    in_ch.burst_frames  = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_RING_READY;
    cfg_ch.data         = '0;
    tx_calm             = 1'b0;
    rx_calm             = 1'b0;
    hold_req            = 1'b0;
    hold_left           = 0;
    cycle_count         = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // ring not ready after reset: nothing below may produce a frame
    send_item(MODE_PUSH, 16'sd100, -16'sd100, 7'd1);
    send_item(MODE_POP, '0, '0, 7'd5);
    send_item(MODE_CLEAR, '0, '0, 7'd1);
    send_item(MODE_UNUSED, '0, '0, 7'd1);

    // ready, no sink: push dropped silently, pop comes back empty
    set_regs(1'b1, 1'b0);
    send_item(MODE_PUSH, 16'sd7, 16'sd9, 7'd1);
    send_item(MODE_POP, '0, '0, 7'd4);

    // normal operation
    set_regs(1'b1, 1'b1);
    send_item(MODE_POP, '0, '0, 7'd0);                    // zero burst on empty ring
    send_item(MODE_PUSH, -16'sd32768, 16'sd32767, 7'd0);  // sample extremes
    send_item(MODE_PUSH, 16'sd32767, -16'sd32768, 7'd127);
    send_item(MODE_PUSH, 16'sd0, 16'sd0, 7'd64);
    send_item(MODE_PUSH, -16'sd1, -16'sd1, 7'd1);
    send_item(MODE_UNUSED, 16'sd5, 16'sd5, 7'd3);         // spare mode ignored
    send_item(MODE_POP, '0, '0, 7'd0);                    // zero burst, frames queued
    send_item(MODE_POP, '0, '0, 7'd1);
    send_item(MODE_POP, '0, '0, 7'd127);                  // oversize, limited by level
    send_item(MODE_PUSH, 16'sh1234, -16'sh4321, 7'd2);
    send_item(MODE_PUSH, 16'sh5555, 16'sh2aaa, 7'd2);
    send_item(MODE_CLEAR, '0, '0, 7'd0);
    send_item(MODE_POP, '0, '0, 7'd1);                    // empty after clear
    send_item(MODE_PUSH, 16'sd42, -16'sd42, 7'd9);
    send_item(MODE_POP, '0, '0, 7'd64);

    // --- random ---
    // long stretch without any idling on either side
    wait_idle();
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    random_items(40, 200);
    wait_idle();
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // idling on both sides, plus a long receiver hold-off while a full
    // burst is pending so the input channel has to stall; the oversize
    // request saturates to the max burst since the level is above it
    random_items(50, 300);
    push_frames(70);
    hold_req = 1'b1;
    send_item(MODE_POP, sample_t'($urandom), sample_t'($urandom), 7'd127);
    random_items(50, 300);

    // sink detached: pushes vanish, pops drain what is left
    set_regs(1'b1, 1'b0);
    random_items(25, 200);

    // ring not ready with sink attached: everything ignored
    set_regs(1'b0, 1'b1);
    random_items(20, 20);

    set_regs(1'b1, 1'b1);
    random_items(60, 300);

    // --- tail ---
    // drain everything with random bursts, then empty pop and clear cases
    while (pred.level > 0)
      send_item(MODE_POP, sample_t'($urandom), sample_t'($urandom),
                burst_t'($urandom_range(127, 1)));
    send_item(MODE_POP, '0, '0, 7'd3);                    // empty, drop count kept
    push_frames(3);
    send_item(MODE_CLEAR, '0, '0, 7'd0);                  // clear with frames queued
    send_item(MODE_POP, '0, '0, 7'd1);
    push_frames(5);
    send_item(MODE_POP, '0, '0, 7'd8);

    // back to reset values for the registers
    set_regs(1'b0, 1'b0);
    send_item(MODE_POP, '0, '0, 7'd1);

    wait_idle();
    if (pred.errors == 0 && pred.expected_frames.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
